FILE: rtl/lwpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package lwpc_pkg;
   localparam int NUM_WAYS   = 8;
   localparam int WAY_BITS   = 3;
   localparam int PAGE_BYTES = 4096;
   localparam int OFF_BITS   = 12;
   localparam int ADDR_BITS  = 48;
   localparam int TAG_BITS   = ADDR_BITS - OFF_BITS;
   localparam int LEN_BITS   = OFF_BITS + 1;
   localparam int SIZE_BITS  = 49;
   localparam int CNT_BITS   = 32;

   typedef enum logic [1:0] {
      OP_READ   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_FLUSH  = 2'd2,
      OP_SHRINK = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ACCESS,
      ST_FLUSH,
      ST_SHRINK
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture request
      logic access;    // run read/write chunk, emit beat
      logic flush;     // emit next flush beat
      logic shrink;    // drop pages, emit beat
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic flush_more;   // dirty way remains after current one
   } stat_type;
endpackage
`default_nettype wire

FILE: rtl/lwpc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module lwpc_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [1:0]        op,
   input  wire lwpc_pkg::stat_type stat,
   output logic                   busy,
   output lwpc_pkg::cmd_type      cmd
);
   lwpc_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= lwpc_pkg::ST_IDLE;
      else       state_ff <= state_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lwpc_pkg::ST_IDLE: begin
            if (start) begin
               case (op)
                  lwpc_pkg::OP_FLUSH:  state_in = lwpc_pkg::ST_FLUSH;
                  lwpc_pkg::OP_SHRINK: state_in = lwpc_pkg::ST_SHRINK;
                  default:             state_in = lwpc_pkg::ST_ACCESS;
               endcase
            end
         end
         lwpc_pkg::ST_FLUSH: if (!stat.flush_more) state_in = lwpc_pkg::ST_IDLE;
         default: state_in = lwpc_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      busy = 1'b1;
      case (state_ff)
         lwpc_pkg::ST_IDLE: begin
            busy = 1'b0;
            cmd.load = start;
         end
         lwpc_pkg::ST_ACCESS: cmd.access = 1'b1;
         lwpc_pkg::ST_FLUSH:  cmd.flush  = 1'b1;
         lwpc_pkg::ST_SHRINK: cmd.shrink = 1'b1;
         default: busy = 1'b1;
      endcase
   end
endmodule
`default_nettype wire

FILE: rtl/lwpc_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module lwpc_datapath (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire lwpc_pkg::cmd_type cmd,
   input  wire logic [1:0]    req_op,
   input  wire logic [47:0]   req_position,
   input  wire logic [31:0]   req_byte_count,
   input  wire logic [48:0]   req_stream_size,
   output lwpc_pkg::stat_type stat,
   output logic               rsp_strobe,
   output logic               rsp_hit,
   output logic [2:0]         rsp_way,
   output logic [11:0]        rsp_page_offset,
   output logic [12:0]        rsp_copy_size,
   output logic               rsp_writeback_needed,
   output logic [47:0]        rsp_writeback_address,
   output logic [12:0]        rsp_writeback_length,
   output logic               rsp_fill_needed,
   output logic [47:0]        rsp_fill_address,
   output logic [12:0]        rsp_fill_length,
   output logic               rsp_last
);
   localparam int N  = lwpc_pkg::NUM_WAYS;
   localparam int WB = lwpc_pkg::WAY_BITS;
   localparam int OB = lwpc_pkg::OFF_BITS;
   localparam int TB = lwpc_pkg::TAG_BITS;
   localparam int LB = lwpc_pkg::LEN_BITS;
   localparam int SB = lwpc_pkg::SIZE_BITS;
   localparam int AB = lwpc_pkg::ADDR_BITS;
   localparam int CB = lwpc_pkg::CNT_BITS;

   // captured request
   logic [1:0]    op_ff;
   logic [AB-1:0] pos_ff;
   logic [CB-1:0] cnt_ff;
   logic [SB-1:0] size_ff;

   // cache state
   logic [TB-1:0] tag_ff   [N];
   logic [N-1:0]  valid_ff, dirty_ff;
   logic [WB-1:0] rank_ff  [N];

   logic [N-1:0]  valid_in, dirty_in;
   logic [WB-1:0] rank_in  [N];
   logic [N-1:0]  tag_we;

   // output beat registers
   logic          strobe_ff, hit_ff, wbn_ff, fn_ff, last_ff;
   logic [WB-1:0] way_ff;
   logic [OB-1:0] off_ff;
   logic [LB-1:0] copy_ff, wbl_ff, fl_ff;
   logic [AB-1:0] wba_ff, fa_ff;

   logic          strobe_in, hit_in, wbn_in, fn_in, last_in;
   logic [WB-1:0] way_in;
   logic [OB-1:0] off_in;
   logic [LB-1:0] copy_in, wbl_in, fl_in;
   logic [AB-1:0] wba_in, fa_in;

   function automatic logic [LB-1:0] span(input logic [SB-1:0] sz,
                                         input logic [AB-1:0] b);
      logic [SB-1:0] d;
      d = (sz > {1'b0, b}) ? sz - {1'b0, b} : '0;
      span = (d < SB'(lwpc_pkg::PAGE_BYTES)) ? d[LB-1:0] : LB'(lwpc_pkg::PAGE_BYTES);
   endfunction

   // request fields
   logic [OB-1:0] off;
   logic [TB-1:0] tag;
   logic [AB-1:0] base;
   logic [SB-1:0] avail;
   logic [CB-1:0] cnt;
   assign off  = pos_ff[OB-1:0];
   assign tag  = pos_ff[AB-1:OB];
   assign base = {tag, {OB{1'b0}}};
   assign avail = (size_ff > {1'b0, pos_ff}) ? size_ff - {1'b0, pos_ff} : '0;
   always_comb begin
      cnt = cnt_ff;
      if (op_ff == lwpc_pkg::OP_READ && {17'd0, cnt_ff} > avail) cnt = avail[CB-1:0];
   end

   // lookup, victim and flush pick
   logic          hit;
   logic [WB-1:0] hit_way, lru_way, fl_way, way;
   logic          fl_any, fl_more;
   logic [N-1:0]  fl_dirty;
   logic [LB-1:0] room;
   always_comb begin
      hit = 1'b0; hit_way = '0; lru_way = '0;
      for (int i = 0; i < N; i++) begin
         if (valid_ff[i] && tag_ff[i] == tag) begin hit = 1'b1; hit_way = WB'(i); end
         if (rank_ff[i] == WB'(N - 1)) lru_way = WB'(i);
      end
   end
   // most recent dirty way: lowest rank
   always_comb begin
      logic [WB:0] best;
      best = (WB+1)'(N);
      fl_way = '0; fl_any = 1'b0;
      for (int i = 0; i < N; i++) begin
         if (dirty_ff[i] && {1'b0, rank_ff[i]} < best) begin
            best = {1'b0, rank_ff[i]}; fl_way = WB'(i); fl_any = 1'b1;
         end
      end
   end
   always_comb begin
      fl_dirty = dirty_ff;
      fl_dirty[fl_way] = 1'b0;
      fl_more = |fl_dirty;
   end
   assign stat.flush_more = fl_more;
   assign way  = hit ? hit_way : lru_way;
   assign room = LB'(lwpc_pkg::PAGE_BYTES) - {1'b0, off};

   // next state and result beat
   always_comb begin
      logic [LB-1:0] need;
      logic [AB-1:0] vb, fb;
      valid_in = valid_ff; dirty_in = dirty_ff; rank_in = rank_ff; tag_we = '0;
      strobe_in = 1'b0; hit_in = 1'b0; way_in = '0; off_in = '0; copy_in = '0;
      wbn_in = 1'b0; wba_in = '0; wbl_in = '0; fn_in = 1'b0; fa_in = '0; fl_in = '0;
      last_in = 1'b0;
      need = span(size_ff, base);
      vb = {tag_ff[way], {OB{1'b0}}};
      fb = {tag_ff[fl_way], {OB{1'b0}}};
      if (cmd.access) begin
         strobe_in = 1'b1; last_in = 1'b1; off_in = off;
         if (cnt != '0) begin
            hit_in = hit; way_in = way;
            copy_in = (cnt < {{(CB-LB){1'b0}}, room}) ? cnt[LB-1:0] : room;
            if (!hit) begin
               if (valid_ff[way] && dirty_ff[way]) begin
                  wbn_in = 1'b1; wba_in = vb; wbl_in = span(size_ff, vb);
               end
               tag_we[way] = 1'b1; valid_in[way] = 1'b1; dirty_in[way] = 1'b0;
               if (op_ff == lwpc_pkg::OP_READ) begin
                  fn_in = 1'b1; fl_in = LB'(lwpc_pkg::PAGE_BYTES); fa_in = base;
               end else if (off != '0 || cnt < {{(CB-LB){1'b0}}, need}) begin
                  fn_in = 1'b1; fl_in = need; fa_in = base;
               end
            end
            if (op_ff == lwpc_pkg::OP_WRITE) dirty_in[way] = 1'b1;
            for (int i = 0; i < N; i++)
               if (rank_ff[i] < rank_ff[way]) rank_in[i] = rank_ff[i] + WB'(1);
            rank_in[way] = '0;
         end
      end else if (cmd.flush) begin
         strobe_in = 1'b1; last_in = !fl_more;
         if (fl_any) begin
            way_in = fl_way; wbn_in = 1'b1; wba_in = fb; wbl_in = span(size_ff, fb);
            dirty_in[fl_way] = 1'b0;
         end
      end else if (cmd.shrink) begin
         strobe_in = 1'b1; last_in = 1'b1;
         for (int i = 0; i < N; i++)
            if (valid_ff[i] && {1'b0, tag_ff[i], {OB{1'b0}}} >= size_ff) begin
               valid_in[i] = 1'b0; dirty_in[i] = 1'b0;
            end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0; dirty_ff <= '0; strobe_ff <= 1'b0;
         for (int i = 0; i < N; i++) rank_ff[i] <= WB'(i);
      end else begin
         valid_ff <= valid_in; dirty_ff <= dirty_in; strobe_ff <= strobe_in;
         rank_ff <= rank_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_op; pos_ff <= req_position;
         cnt_ff <= req_byte_count; size_ff <= req_stream_size;
      end
      for (int i = 0; i < N; i++) if (tag_we[i]) tag_ff[i] <= tag;
      hit_ff <= hit_in; way_ff <= way_in; off_ff <= off_in; copy_ff <= copy_in;
      wbn_ff <= wbn_in; wba_ff <= wba_in; wbl_ff <= wbl_in;
      fn_ff <= fn_in; fa_ff <= fa_in; fl_ff <= fl_in; last_ff <= last_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_hit = hit_ff;
   assign rsp_way = way_ff;
   assign rsp_page_offset = off_ff;
   assign rsp_copy_size = copy_ff;
   assign rsp_writeback_needed = wbn_ff;
   assign rsp_writeback_address = wba_ff;
   assign rsp_writeback_length = wbl_ff;
   assign rsp_fill_needed = fn_ff;
   assign rsp_fill_address = fa_ff;
   assign rsp_fill_length = fl_ff;
   assign rsp_last = last_ff;
endmodule
`default_nettype wire

FILE: rtl/lru_writeback_page_cache_control.sv
`timescale 1ns / 1ps
`default_nettype none
// Fully associative 8-way LRU write-back page cache controller (tags only).
// Request channel: req_op, req_position, req_byte_count, req_stream_size are
// taken on a rising edge with start high and busy low.
// Result channel: each beat sits on the rsp_ ports for one cycle, marked by
// rsp_strobe; the receiver cannot stall, so beats are never held back.
// Read, write and shrink give one beat, registered in the ACCESS or SHRINK
// state; busy stays high until then, and the next request is taken at the
// edge at which that beat is taken. Flush gives one beat per dirty way (at
// least one), one per cycle, most recent first; the sequencer walks dirty
// ways in recency order one per cycle.
// rsp_last marks the final beat of a request.
// Reset clears all valid and dirty bits, sets way i to recency rank i and
// returns the sequencer to idle; tags are only read while valid.
module lru_writeback_page_cache_control (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_op,
   input  wire logic [47:0] req_position,
   input  wire logic [31:0] req_byte_count,
   input  wire logic [48:0] req_stream_size,
   output logic             rsp_strobe,
   output logic             rsp_hit,
   output logic [2:0]       rsp_way,
   output logic [11:0]      rsp_page_offset,
   output logic [12:0]      rsp_copy_size,
   output logic             rsp_writeback_needed,
   output logic [47:0]      rsp_writeback_address,
   output logic [12:0]      rsp_writeback_length,
   output logic             rsp_fill_needed,
   output logic [47:0]      rsp_fill_address,
   output logic [12:0]      rsp_fill_length,
   output logic             rsp_last
);
   lwpc_pkg::cmd_type  cmd;
   lwpc_pkg::stat_type stat;

   lwpc_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .op(req_op),
      .stat(stat), .busy(busy), .cmd(cmd)
   );

   lwpc_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .req_op(req_op), .req_position(req_position),
      .req_byte_count(req_byte_count), .req_stream_size(req_stream_size),
      .stat(stat), .rsp_strobe(rsp_strobe), .rsp_hit(rsp_hit), .rsp_way(rsp_way),
      .rsp_page_offset(rsp_page_offset), .rsp_copy_size(rsp_copy_size),
      .rsp_writeback_needed(rsp_writeback_needed),
      .rsp_writeback_address(rsp_writeback_address),
      .rsp_writeback_length(rsp_writeback_length),
      .rsp_fill_needed(rsp_fill_needed), .rsp_fill_address(rsp_fill_address),
      .rsp_fill_length(rsp_fill_length), .rsp_last(rsp_last)
   );
endmodule
`default_nettype wire
